// ===== design/dlq_pkg.sv =====
// shared types and constants for the deadline event queue
`timescale 1ns / 1ps
package dlq_pkg;

    localparam int SLOTS = 16;
    localparam int QCAP  = (SLOTS < 16) ? SLOTS : 16;
    localparam int CMD_W = 2;
    localparam int SL_W  = 4;
    localparam int DL_W  = 64;
    localparam int HD_W  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_MATCH  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_CMP    = 3'd3,
        OP_INSERT = 3'd4,
        OP_POP    = 3'd5
    } t_cell_op;

    typedef struct packed {
        logic            valid;
        logic [DL_W-1:0] deadline;
        logic [HD_W-1:0] handler;
        logic [SL_W-1:0] slot;
    } t_entry;

    typedef struct packed {
        t_cell_op        op;
        logic [SL_W-1:0] key_slot;
        logic [DL_W-1:0] key_time;
        logic [HD_W-1:0] new_handler;
    } t_cell_ctl;

endpackage

// ===== design/dlq_cell.sv =====
// one position of the sorted event chain
`timescale 1ns / 1ps
module dlq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlq_pkg::t_cell_ctl i_ctl,
    input  dlq_pkg::t_entry   i_left,
    input  logic              i_left_le,
    input  dlq_pkg::t_entry   i_right,
    input  logic              i_right_le,
    input  logic              i_prev_hit,
    output dlq_pkg::t_entry   o_ent,
    output logic              o_le,
    output logic              o_hit,
    output logic              o_first
);
    import dlq_pkg::*;

    logic            r_valid;
    logic            r_le;
    logic            r_match;
    logic [DL_W-1:0] r_deadline;
    logic [HD_W-1:0] r_handler;
    logic [SL_W-1:0] r_slot;

    assign o_hit   = i_prev_hit | r_match;
    assign o_le    = r_le;
    assign o_first = i_left_le & ~r_le & r_valid;
    assign o_ent   = '{valid: r_valid, deadline: r_deadline, handler: r_handler, slot: r_slot};

    // flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_le    <= 1'b0;
            r_match <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_MATCH: begin
                    r_match <= r_valid && (r_slot == i_ctl.key_slot);
                end
                OP_CMP: begin
                    r_le <= r_valid && (r_deadline <= i_ctl.key_time);
                end
                OP_REMOVE: begin
                    if (o_hit) begin
                        r_valid <= i_right.valid;
                    end
                end
                OP_INSERT: begin
                    if (!r_le) begin
                        r_valid <= i_left_le ? 1'b1 : i_left.valid;
                    end
                end
                OP_POP: begin
                    r_valid <= i_right.valid;
                    r_le    <= i_right_le;
                end
                default: begin
                end
            endcase
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_REMOVE, OP_POP: begin
                if (o_hit || i_ctl.op == OP_POP) begin
                    r_deadline <= i_right.deadline;
                    r_handler  <= i_right.handler;
                    r_slot     <= i_right.slot;
                end
            end
            OP_INSERT: begin
                if (!r_le) begin
                    if (i_left_le) begin
                        r_deadline <= i_ctl.key_time;
                        r_handler  <= i_ctl.new_handler;
                        r_slot     <= i_ctl.key_slot;
                    end else begin
                        r_deadline <= i_left.deadline;
                        r_handler  <= i_left.handler;
                        r_slot     <= i_left.slot;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/deadline_event_queue.sv =====
// sorted deadline event queue built from a chain of cells
// steps: add runs match, remove, compare, insert; remove runs match, remove; check runs
//   compare, select, then a pop per expired event; every request ends in the final state
// requests: one at a time, the input stalls outside idle; the slot match, chain shift and
//   deadline compare each act on the whole cell chain at once
// reset: synchronous active-low reset empties the queue and drops any pending result
`timescale 1ns / 1ps
module deadline_event_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [dlq_pkg::CMD_W-1:0] i_cmd,
    input  logic [dlq_pkg::SL_W-1:0]  i_slot,
    input  logic [dlq_pkg::DL_W-1:0]  i_deadline,
    input  logic [dlq_pkg::HD_W-1:0]  i_handler,
    input  logic [dlq_pkg::DL_W-1:0]  i_now_time,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_fired,
    output logic [dlq_pkg::HD_W-1:0]  o_fired_handler,
    output logic [dlq_pkg::SL_W-1:0]  o_fired_slot,
    output logic [dlq_pkg::DL_W-1:0]  o_next_check_time,
    output logic                      o_last
);
    import dlq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MATCH  = 8'b0000_0010,
        S_REMOVE = 8'b0000_0100,
        S_CMP    = 8'b0000_1000,
        S_INSERT = 8'b0001_0000,
        S_SEL    = 8'b0010_0000,
        S_POP    = 8'b0100_0000,
        S_FINAL  = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [SL_W-1:0] r_slot;
    logic [DL_W-1:0] r_deadline;
    logic [HD_W-1:0] r_handler;
    logic [DL_W-1:0] r_now;
    logic [DL_W-1:0] r_next, n_next;

    logic            r_out_valid;
    logic            r_out_fired;
    logic [HD_W-1:0] r_out_handler;
    logic [SL_W-1:0] r_out_slot;
    logic [DL_W-1:0] r_out_next;
    logic            r_out_last;

    t_cell_ctl       w_ctl;
    t_entry          c_ent [QCAP];
    logic [QCAP-1:0] c_le;
    logic [QCAP-1:0] c_hit;
    logic [QCAP-1:0] c_first;
    logic [QCAP-1:0] w_vld;
    logic            w_accept;
    logic            w_load;
    logic            w_pop;
    logic            w_slot_ok;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = !r_out_valid || !i_out_stall;
    assign w_pop      = c_le[0];
    assign w_slot_ok  = (32'(i_slot) < SLOTS);

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < QCAP; gi++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_le;
            logic   w_right_le;
            logic   w_prev_hit;
            if (gi == 0) begin : g_head
                assign w_left     = '0;
                assign w_left_le  = 1'b1;
                assign w_prev_hit = 1'b0;
            end else begin : g_mid
                assign w_left     = c_ent[gi-1];
                assign w_left_le  = c_le[gi-1];
                assign w_prev_hit = c_hit[gi-1];
            end
            if (gi == QCAP - 1) begin : g_tail
                assign w_right    = '0;
                assign w_right_le = 1'b0;
            end else begin : g_body
                assign w_right    = c_ent[gi+1];
                assign w_right_le = c_le[gi+1];
            end
            dlq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_left     (w_left),
                .i_left_le  (w_left_le),
                .i_right    (w_right),
                .i_right_le (w_right_le),
                .i_prev_hit (w_prev_hit),
                .o_ent      (c_ent[gi]),
                .o_le       (c_le[gi]),
                .o_hit      (c_hit[gi]),
                .o_first    (c_first[gi])
            );
            assign w_vld[gi] = c_ent[gi].valid;
        end
    endgenerate

    // cell control
    always_comb begin
        w_ctl.key_slot    = r_slot;
        w_ctl.key_time    = (r_cmd == CMD_ADD) ? r_deadline : r_now;
        w_ctl.new_handler = r_handler;
        case (r_state)
            S_MATCH:  w_ctl.op = OP_MATCH;
            S_REMOVE: w_ctl.op = OP_REMOVE;
            S_CMP:    w_ctl.op = OP_CMP;
            S_INSERT: w_ctl.op = OP_INSERT;
            S_POP:    w_ctl.op = (w_pop && w_load) ? OP_POP : OP_HOLD;
            default:  w_ctl.op = OP_HOLD;
        endcase
    end

    // earliest deadline left after the pops
    always_comb begin
        n_next = '0;
        for (int i = 0; i < QCAP; i++) begin
            n_next = n_next | ({DL_W{c_first[i]}} & c_ent[i].deadline);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_cmd == CMD_ADD || i_cmd == CMD_REMOVE) && w_slot_ok) begin
                        n_state = S_MATCH;
                    end else if (i_cmd == CMD_CHECK) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_MATCH:  n_state = S_REMOVE;
            S_REMOVE: n_state = (r_cmd == CMD_ADD) ? S_CMP : S_FINAL;
            S_CMP:    n_state = (r_cmd == CMD_ADD) ? S_INSERT : S_SEL;
            S_INSERT: n_state = S_FINAL;
            S_SEL:    n_state = S_POP;
            S_POP: begin
                if (!w_pop) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= (r_state == S_POP && w_pop) || (r_state == S_FINAL);
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_slot     <= i_slot;
            r_deadline <= i_deadline;
            r_handler  <= i_handler;
            r_now      <= i_now_time;
        end
        if (r_state == S_SEL) begin
            r_next <= n_next;
        end
        if (w_load) begin
            if (r_state == S_POP) begin
                r_out_fired   <= 1'b1;
                r_out_handler <= c_ent[0].handler;
                r_out_slot    <= c_ent[0].slot;
                r_out_next    <= r_next;
                r_out_last    <= 1'b0;
            end else begin
                r_out_fired   <= 1'b0;
                r_out_handler <= '0;
                r_out_slot    <= '0;
                r_out_next    <= c_ent[0].valid ? c_ent[0].deadline : '0;
                r_out_last    <= 1'b1;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fired           = r_out_fired;
    assign o_fired_handler   = r_out_handler;
    assign o_fired_slot      = r_out_slot;
    assign o_next_check_time = r_out_next;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    // occupied positions form an unbroken run from the head
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld >> 1) & ~w_vld) == '0)
        else $error("queue has a gap");

    // expired events are reported only for a check request
    a_fired_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fired) |-> (r_cmd == CMD_CHECK))
        else $error("fired result outside a check");

    // the final result closes the request and frees the input
    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && w_load) |=> (r_out_valid && r_out_last && r_state == S_IDLE))
        else $error("final result not delivered");

    // a popped event always comes from an occupied head
    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_POP) |-> (c_ent[0].valid && r_state == S_POP))
        else $error("pop from empty head");
`endif

endmodule
